// ----- rtl/tri_adj_pkg.sv -----
// Shared types, sizes and codes for the triangle edge adjacency core.
package tri_adj_pkg;

   localparam int MAX_TRIANGLES = 16;
   localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
   localparam int VTX_W = 16;
   localparam int TRI_W = 4;

   // Edge codes of a triangle: a-b, b-c, c-a.
   localparam logic [1:0] EDGE_AB = 2'd0;
   localparam logic [1:0] EDGE_BC = 2'd1;
   localparam logic [1:0] EDGE_CA = 2'd2;

   typedef struct packed {
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
      logic [VTX_W-1:0] vertex_c;
      logic             final_item;
   } req_payload_type;

   typedef struct packed {
      logic [VTX_W-1:0] edge_start;
      logic [VTX_W-1:0] edge_end;
      logic [TRI_W-1:0] first_tri;
      logic [TRI_W-1:0] second_tri;
      logic             is_end;
      logic             overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] rd_addr;
      logic             latch_tri;
      logic             compare;
      logic [IDX_W-1:0] scan_idx;
      logic [IDX_W-1:0] tri_idx;
      logic             emit_edge;
      logic [1:0]       edge_sel;
      logic             emit_end;
   } tri_adj_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } tri_adj_status_type;

endpackage

// ----- rtl/triangle_edge_adjacency_core.sv -----
// Top level of the triangle edge adjacency core: controller plus datapath.
//
//  channel   ports                        handshake
//  request   start, busy, req_data        taken when start && !busy
//  result    rsp_strobe, rsp_data         a one-cycle strobe per result, no back-pressure
//
//  Loading takes one request per cycle while busy is low.
//  After the final request the search runs with busy high: each triangle with a later
//  one is read and latched, every later triangle is read and compared on the
//  single read port of the store, and each of its edges that a later triangle shares
//  is emitted; a closing check and the end result finish the search.
//  The end result leaves in the cycle busy drops; a new request may be taken then.
//  Synchronous reset clears the run count, drop flag, match flags, result strobe and controller.
module triangle_edge_adjacency_core
   import tri_adj_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_data
);

   tri_adj_cmd_type    cmd;
   tri_adj_status_type status;

   tri_adj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_item (req_data.final_item),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   tri_adj_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_final_starts_search: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.final_item) |=> busy)
      else $error("final request did not start the search");

   a_edge_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_end) |-> (rsp_data.first_tri < rsp_data.second_tri))
      else $error("edge result pairs triangles out of order");

   a_end_with_idle: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_data.is_end))
      else $error("search ended without an end result");

   a_no_end_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(rsp_strobe && rsp_data.is_end))
      else $error("end result while search still running");

endmodule

// ----- rtl/tri_adj_dpath.sv -----
// Datapath: triangle store, current triangle, edge match tracking and result register.
module tri_adj_dpath
   import tri_adj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_payload_type    req_data,
   input  tri_adj_cmd_type    cmd,
   output tri_adj_status_type status,
   output logic               rsp_strobe,
   output rsp_payload_type    rsp_data
);

   logic [3*VTX_W-1:0] store_ff [MAX_TRIANGLES];
   logic [3*VTX_W-1:0] rdata_ff;
   logic [3*VTX_W-1:0] tri_i_ff, tri_i_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [2:0]         found_ff, found_in;
   logic [IDX_W-1:0]   match_ff [3];
   logic [IDX_W-1:0]   match_in [3];
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               has_room;
   logic [VTX_W-1:0]   ti_a, ti_b, ti_c, tj_a, tj_b, tj_c;
   logic [VTX_W-1:0]   edge_x [3];
   logic [VTX_W-1:0]   edge_y [3];

   function automatic logic holds_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                       input logic [VTX_W-1:0] c, input logic [VTX_W-1:0] x,
                                       input logic [VTX_W-1:0] y);
      holds_edge = (a == x && (b == y || c == y)) ||
                   (b == x && (a == y || c == y)) ||
                   (c == x && (a == y || b == y));
   endfunction

   assign has_room = count_ff < CNT_W'(MAX_TRIANGLES);

   assign ti_a = tri_i_ff[3*VTX_W-1:2*VTX_W];
   assign ti_b = tri_i_ff[2*VTX_W-1:VTX_W];
   assign ti_c = tri_i_ff[VTX_W-1:0];
   assign tj_a = rdata_ff[3*VTX_W-1:2*VTX_W];
   assign tj_b = rdata_ff[2*VTX_W-1:VTX_W];
   assign tj_c = rdata_ff[VTX_W-1:0];

   assign edge_x[0] = ti_a;
   assign edge_y[0] = ti_b;
   assign edge_x[1] = ti_b;
   assign edge_y[1] = ti_c;
   assign edge_x[2] = ti_c;
   assign edge_y[2] = ti_a;

   // Store and single read port.
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         store_ff[count_ff[IDX_W-1:0]] <= {req_data.vertex_a, req_data.vertex_b,
                                          req_data.vertex_c};
      end
      rdata_ff <= store_ff[cmd.rd_addr];
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.emit_end) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.load) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_comb begin
      tri_i_in = tri_i_ff;
      found_in = found_ff;
      for (int e = 0; e < 3; e++) begin
         match_in[e] = match_ff[e];
      end
      if (cmd.latch_tri) begin
         tri_i_in = rdata_ff;
         found_in = '0;
      end else if (cmd.compare) begin
         // keep only the first later triangle for each edge
         for (int e = 0; e < 3; e++) begin
            if (!found_ff[e] && holds_edge(tj_a, tj_b, tj_c, edge_x[e], edge_y[e])) begin
               found_in[e] = 1'b1;
               match_in[e] = cmd.scan_idx;
            end
         end
      end
   end

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      if (cmd.emit_end) begin
         rsp_strobe_in        = 1'b1;
         rsp_data_in.is_end   = 1'b1;
         rsp_data_in.overflow = dropped_ff;
      end else if (cmd.emit_edge) begin
         rsp_data_in.first_tri = TRI_W'(cmd.tri_idx);
         case (cmd.edge_sel)
            EDGE_AB: begin
               rsp_strobe_in          = found_ff[0];
               rsp_data_in.edge_start = edge_x[0];
               rsp_data_in.edge_end   = edge_y[0];
               rsp_data_in.second_tri = TRI_W'(match_ff[0]);
            end
            EDGE_BC: begin
               rsp_strobe_in          = found_ff[1];
               rsp_data_in.edge_start = edge_x[1];
               rsp_data_in.edge_end   = edge_y[1];
               rsp_data_in.second_tri = TRI_W'(match_ff[1]);
            end
            EDGE_CA: begin
               rsp_strobe_in          = found_ff[2];
               rsp_data_in.edge_start = edge_x[2];
               rsp_data_in.edge_end   = edge_y[2];
               rsp_data_in.second_tri = TRI_W'(match_ff[2]);
            end
            default: begin
               rsp_strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         found_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tri_i_ff    <= tri_i_in;
      rsp_data_ff <= rsp_data_in;
      for (int e = 0; e < 3; e++) begin
         match_ff[e] <= match_in[e];
      end
   end

   assign status.count = count_ff;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

// ----- rtl/tri_adj_ctrl.sv -----
// Controller: load phase, pairwise search sequence and result emission.
module tri_adj_ctrl
   import tri_adj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               final_item,
   input  tri_adj_status_type status,
   output logic               busy,
   output tri_adj_cmd_type    cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_RD_I  = 3'd1;
   localparam logic [2:0] S_LAT_I = 3'd2;
   localparam logic [2:0] S_RD_J  = 3'd3;
   localparam logic [2:0] S_CMP_J = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_END   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [1:0]       e_ff, e_in;
   logic             accept;

   assign accept = start && (state_ff == S_LOAD);

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      e_in          = e_ff;
      cmd           = '0;
      cmd.scan_idx  = j_ff;
      cmd.tri_idx   = i_ff;
      cmd.edge_sel  = e_ff;
      cmd.rd_addr   = j_ff;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load = accept;
            if (accept && final_item) begin
               i_in     = '0;
               state_in = S_RD_I;
            end
         end
         S_RD_I: begin
            cmd.rd_addr = i_ff;
            // stop once no later triangle is left to pair with
            if (CNT_W'(i_ff) + CNT_W'(1) >= status.count) begin
               state_in = S_END;
            end else begin
               state_in = S_LAT_I;
            end
         end
         S_LAT_I: begin
            cmd.latch_tri = 1'b1;
            j_in          = i_ff + IDX_W'(1);
            state_in      = S_RD_J;
         end
         S_RD_J: begin
            state_in = S_CMP_J;
         end
         S_CMP_J: begin
            cmd.compare = 1'b1;
            if (CNT_W'(j_ff) + CNT_W'(1) == status.count) begin
               e_in     = EDGE_AB;
               state_in = S_EMIT;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_RD_J;
            end
         end
         S_EMIT: begin
            cmd.emit_edge = 1'b1;
            if (e_ff == EDGE_CA) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_RD_I;
            end else begin
               e_in = e_ff + 2'd1;
            end
         end
         S_END: begin
            cmd.emit_end = 1'b1;
            state_in     = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         i_ff     <= '0;
         j_ff     <= '0;
         e_ff     <= EDGE_AB;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         e_ff     <= e_in;
      end
   end

   assign busy = (state_ff != S_LOAD);

endmodule
